// ===== src/srfa_pkg.sv =====
// ----------------------------------------------------------------------------
// srfa_pkg
// Shared types and constants of the serial receive frame assembler.
// ----------------------------------------------------------------------------
package srfa_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int RIDX_W   = 6;
    localparam int LEN_W    = 7;
    localparam int TICKS_W  = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_BYTE    = 2'd0,
        FUNC_TICK    = 2'd1,
        FUNC_RELEASE = 2'd2,
        FUNC_READ    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_TERM    = 2'd1,
        CAUSE_TIMEOUT = 2'd2,
        CAUSE_FULL    = 2'd3
    } cause_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT_TICKS = 2'd0,
        REG_TERM_ENABLE   = 2'd1,
        REG_FIRST_TERM    = 2'd2,
        REG_SECOND_TERM   = 2'd3
    } reg_idx_t;

    localparam logic [TICKS_W-1:0] TICKS_RESET      = 7'd10;
    localparam logic               TERM_EN_RESET    = 1'b1;
    localparam logic [BYTE_W-1:0]  FIRST_TERM_RESET = 8'h0D;
    localparam logic [BYTE_W-1:0]  SECOND_TERM_RESET = 8'h0A;

endpackage

// ===== src/serial_rx_frame_assembler.sv =====
// ----------------------------------------------------------------------------
// serial_rx_frame_assembler
// Collects received bytes into frames; closes on terminator, full buffer
// or idle timeout, and holds the closed frame until it is released.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid / in_ready    | func, rx_byte, read_index
//  out     | output    | out_valid / out_ready  | read_data, frame_ready,
//          |           |                        | frame_length, frame_cause,
//          |           |                        | receiving
//  cfg     | input     | cfg_write_en           | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; an item's result is
// offered after the input register, then the state update and buffer access.
// The buffer read port is registered alongside the state registers.
// Reset clears control state and loads the register defaults; the buffer
// holds no reset value. A stalled output holds one result while one more
// item waits in the input register.
// ----------------------------------------------------------------------------
module serial_rx_frame_assembler
    import srfa_pkg::*;
#(
    parameter int BUFFER_DEPTH = DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FUNC_W-1:0]    func,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic [RIDX_W-1:0]    read_index,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    read_data,
    output logic                 frame_ready,
    output logic [LEN_W-1:0]     frame_length,
    output logic [1:0]           frame_cause,
    output logic                 receiving,

    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int WW = $clog2(BUFFER_DEPTH + 1);
    localparam int CW = (WW > 9) ? WW : 9;

    // configuration
    logic [TICKS_W-1:0] ticks_reg;
    logic               term_en_reg;
    logic [BYTE_W-1:0]  first_term_reg;
    logic [BYTE_W-1:0]  second_term_reg;

    // input register
    logic               s1_valid_reg;
    func_t              s1_func_reg;
    logic [BYTE_W-1:0]  s1_byte_reg;
    logic [RIDX_W-1:0]  s1_idx_reg;

    // frame state
    logic [WW-1:0]      wr_idx_reg,  wr_idx_next;
    logic [BYTE_W-1:0]  prev_reg,    prev_next;
    logic [LEN_W-1:0]   held_len_reg, held_len_next;
    logic               held_reg,    held_next;
    cause_t             cause_reg,   cause_next;
    logic               in_frame_reg, in_frame_next;
    logic [TICKS_W-1:0] tleft_reg,   tleft_next;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  rd_data_reg;

    logic [BYTE_W-1:0]  rx_buffer [BUFFER_DEPTH];

    logic               advance;
    logic               store_byte;
    logic [WW-1:0]      wr_idx_inc;
    logic               read_hit;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    assign wr_idx_inc = wr_idx_reg + 1'b1;
    assign wr_addr    = wr_idx_reg[AW-1:0];
    assign rd_addr    = AW'(s1_idx_reg);
    assign read_hit   = (s1_func_reg == FUNC_READ) &&
                        (CW'(s1_idx_reg) < CW'(BUFFER_DEPTH));

    always_comb
    begin
        wr_idx_next   = wr_idx_reg;
        prev_next     = prev_reg;
        held_len_next = held_len_reg;
        held_next     = held_reg;
        cause_next    = cause_reg;
        in_frame_next = in_frame_reg;
        tleft_next    = tleft_reg;
        store_byte    = 1'b0;

        case (s1_func_reg)
            FUNC_BYTE:
            begin
                if (held_reg)
                begin
                    // drop the byte while a frame is held
                    in_frame_next = 1'b0;
                    tleft_next    = ticks_reg;
                end
                else if (wr_idx_reg != '0 && tleft_reg == '0)
                begin
                    // silence ran out: close, drop the byte
                    held_next     = 1'b1;
                    held_len_next = LEN_W'(wr_idx_reg);
                    cause_next    = CAUSE_TIMEOUT;
                    wr_idx_next   = '0;
                    in_frame_next = 1'b0;
                end
                else
                begin
                    store_byte = 1'b1;
                    tleft_next = ticks_reg;
                    prev_next  = s1_byte_reg;
                    if (wr_idx_reg == '0)
                    begin
                        in_frame_next = 1'b1;
                    end
                    if (wr_idx_reg != '0 && term_en_reg &&
                        prev_reg == first_term_reg && s1_byte_reg == second_term_reg)
                    begin
                        held_next     = 1'b1;
                        held_len_next = LEN_W'(wr_idx_inc);
                        cause_next    = CAUSE_TERM;
                        wr_idx_next   = '0;
                        in_frame_next = 1'b0;
                    end
                    else if (wr_idx_inc == WW'(BUFFER_DEPTH))
                    begin
                        held_next     = 1'b1;
                        held_len_next = LEN_W'(wr_idx_inc);
                        cause_next    = CAUSE_FULL;
                        wr_idx_next   = '0;
                        in_frame_next = 1'b0;
                    end
                    else
                    begin
                        wr_idx_next = wr_idx_inc;
                    end
                end
            end
            FUNC_TICK:
            begin
                if (tleft_reg != '0)
                begin
                    tleft_next = tleft_reg - 1'b1;
                end
            end
            FUNC_RELEASE:
            begin
                if (held_reg)
                begin
                    held_next     = 1'b0;
                    held_len_next = '0;
                    cause_next    = CAUSE_NONE;
                    tleft_next    = ticks_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg       <= TICKS_RESET;
            term_en_reg     <= TERM_EN_RESET;
            first_term_reg  <= FIRST_TERM_RESET;
            second_term_reg <= SECOND_TERM_RESET;
        end
        else if (cfg_write_en)
        begin
            case (reg_idx_t'(cfg_index))
                REG_TIMEOUT_TICKS: ticks_reg       <= cfg_data[TICKS_W-1:0];
                REG_TERM_ENABLE:   term_en_reg     <= cfg_data[0];
                REG_FIRST_TERM:    first_term_reg  <= cfg_data;
                REG_SECOND_TERM:   second_term_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wr_idx_reg    <= '0;
            prev_reg      <= '0;
            held_len_reg  <= '0;
            held_reg      <= 1'b0;
            cause_reg     <= CAUSE_NONE;
            in_frame_reg  <= 1'b0;
            tleft_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                wr_idx_reg   <= wr_idx_next;
                prev_reg     <= prev_next;
                held_len_reg <= held_len_next;
                held_reg     <= held_next;
                cause_reg    <= cause_next;
                in_frame_reg <= in_frame_next;
                tleft_reg    <= tleft_next;
            end
        end
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_func_reg <= func_t'(func);
            s1_byte_reg <= rx_byte;
            s1_idx_reg  <= read_index;
        end
    end

    // buffer: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (advance && store_byte)
        begin
            rx_buffer[wr_addr] <= s1_byte_reg;
        end
        if (advance)
        begin
            if (read_hit)
            begin
                rd_data_reg <= rx_buffer[rd_addr];
            end
            else
            begin
                rd_data_reg <= '0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_data    = rd_data_reg;
    assign frame_ready  = held_reg;
    assign frame_length = held_len_reg;
    assign frame_cause  = cause_reg;
    assign receiving    = in_frame_reg;

endmodule
